@@ hdl/mpwl_pkg.sv @@
// ----------------------------------------------------------------------------
// mpwl_pkg
// shared types, register indexes and widths for the pixel window/level block
// ----------------------------------------------------------------------------
package mpwl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIX_W      = 16;
  localparam int EXT_W      = PIX_W + 1;
  localparam int SLOPE_W    = 24;
  localparam int SCALE_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int RPROD_W    = EXT_W + SLOPE_W;
  localparam int RSUM_W     = RPROD_W + 1;
  localparam int RTRUNC_W   = RSUM_W - FRAC_BITS;
  localparam int DIFF_W     = PIX_W + 1;
  localparam int WPROD_W    = DIFF_W + SCALE_W + 1;
  localparam int WQUOT_W    = WPROD_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SCALE = 3'd5;

  typedef struct packed {
    logic [3:0]                high_bit;
    logic                      is_signed;
    logic signed [SLOPE_W-1:0] rescale_slope;
    logic signed [PIX_W-1:0]   rescale_intercept;
    logic signed [PIX_W-1:0]   window_low;
    logic [SCALE_W-1:0]        window_scale;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic frame;
  } stage_t;

endpackage

@@ hdl/mpwl_cfg.sv @@
// ----------------------------------------------------------------------------
// mpwl_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module mpwl_cfg import mpwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_bit          <= 4'd15;
      cfg.is_signed         <= 1'b0;
      cfg.rescale_slope     <= SLOPE_W'(1 << FRAC_BITS);
      cfg.rescale_intercept <= '0;
      cfg.window_low        <= '0;
      cfg.window_scale      <= SCALE_W'(1 << FRAC_BITS);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HIGH_BIT:     cfg.high_bit          <= wr_data[3:0];
        REG_IS_SIGNED:    cfg.is_signed         <= wr_data[0];
        REG_SLOPE:        cfg.rescale_slope     <= wr_data[SLOPE_W-1:0];
        REG_INTERCEPT:    cfg.rescale_intercept <= wr_data[PIX_W-1:0];
        REG_WINDOW_LOW:   cfg.window_low        <= wr_data[PIX_W-1:0];
        REG_WINDOW_SCALE: cfg.window_scale      <= wr_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/mpwl_rescale.sv @@
// ----------------------------------------------------------------------------
// mpwl_rescale
// stored-bit extraction and modality rescale, four register stages
// ----------------------------------------------------------------------------
module mpwl_rescale import mpwl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  input  logic [PIX_W-1:0]        raw_pixel,
  input  logic                    frame_last,
  output stage_t                  out_ctl,
  output logic signed [PIX_W-1:0] out_value
);

  stage_t ctl1, ctl2, ctl3;
  logic signed [EXT_W-1:0]   ext1, ext_next;
  logic signed [RPROD_W-1:0] prod2, prod_next;
  logic signed [RSUM_W-1:0]  sum3, sum_next, icpt;
  logic signed [RSUM_W-1:0]  biased;
  logic signed [RTRUNC_W-1:0] trunc;
  logic signed [PIX_W-1:0]   sat_next;
  logic                      fill;

  // keep stored bits, fill above high bit with zero or sign
  always_comb begin
    fill = cfg.is_signed & raw_pixel[cfg.high_bit];
    for (int i = 0; i < PIX_W; i++) begin
      ext_next[i] = (4'(i) <= cfg.high_bit) ? raw_pixel[i] : fill;
    end
    ext_next[EXT_W-1] = fill;
  end

  assign prod_next = ext1 * cfg.rescale_slope;

  always_comb begin
    icpt     = {{(RSUM_W-PIX_W-FRAC_BITS){cfg.rescale_intercept[PIX_W-1]}},
                cfg.rescale_intercept, FRAC_BITS'(0)};
    sum_next = {prod2[RPROD_W-1], prod2} + icpt;
  end

  // truncate toward zero, then saturate to 16-bit signed
  always_comb begin
    biased = sum3 + (sum3[RSUM_W-1] ? RSUM_W'((1 << FRAC_BITS) - 1) : RSUM_W'(0));
    trunc  = biased[RSUM_W-1:FRAC_BITS];
    if (trunc > RTRUNC_W'(32767)) begin
      sat_next = 16'sh7FFF;
    end else if (trunc < -RTRUNC_W'(32768)) begin
      sat_next = 16'sh8000;
    end else begin
      sat_next = trunc[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      out_ctl <= '0;
    end else begin
      ctl1    <= '{valid: in_valid, frame: frame_last};
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      out_ctl <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    ext1      <= ext_next;
    prod2     <= prod_next;
    sum3      <= sum_next;
    out_value <= sat_next;
  end

endmodule

@@ hdl/mpwl_window.sv @@
// ----------------------------------------------------------------------------
// mpwl_window
// window/level mapping to 8-bit display and half-range offset, three stages
// ----------------------------------------------------------------------------
module mpwl_window import mpwl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  stage_t                  in_ctl,
  input  logic signed [PIX_W-1:0] in_value,
  output logic                    done,
  output logic [7:0]              display_value,
  output logic [PIX_W-1:0]        offset_value,
  output logic                    frame_end
);

  stage_t ctl5, ctl6;
  logic signed [DIFF_W-1:0]  diff5, diff_next;
  logic signed [WPROD_W-1:0] prod6, prod_next;
  logic [PIX_W-1:0]          offs5, offs6, offs_next;
  logic [WQUOT_W-1:0]        quot;
  logic [7:0]                disp_next;

  assign diff_next = {in_value[PIX_W-1], in_value} -
                     {cfg.window_low[PIX_W-1], cfg.window_low};
  assign offs_next = {in_value[PIX_W-1] ^ cfg.is_signed, in_value[PIX_W-2:0]};
  assign prod_next = diff5 * $signed({1'b0, cfg.window_scale});

  always_comb begin
    quot = prod6[WPROD_W-1:FRAC_BITS];
    if (prod6 <= 0) begin
      disp_next = 8'd0;
    end else if (|quot[WQUOT_W-1:8]) begin
      disp_next = 8'd255;
    end else begin
      disp_next = quot[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl5 <= '0;
      ctl6 <= '0;
      done <= 1'b0;
    end else begin
      ctl5 <= in_ctl;
      ctl6 <= ctl5;
      done <= ctl6.valid;
    end
  end

  always_ff @(posedge clk) begin
    diff5         <= diff_next;
    offs5         <= offs_next;
    prod6         <= prod_next;
    offs6         <= offs5;
    display_value <= disp_next;
    offset_value  <= offs6;
    frame_end     <= ctl6.frame;
  end

endmodule

@@ hdl/medical_pixel_window_level_top.sv @@
// ----------------------------------------------------------------------------
// medical_pixel_window_level_top
// pixel window/level: stored-bit extraction, rescale, windowing and offset
// ----------------------------------------------------------------------------
// One pixel is taken per clock; busy never rises. Each pixel gives one
// result on done after passing through the seven register stages (extract,
// rescale multiply, intercept add, truncate and saturate, window subtract,
// window multiply, clamp). The receiver cannot stall; results appear in
// input order. The user must write registers only while no transaction is
// in flight; the block itself does not enforce this.
module medical_pixel_window_level_top import mpwl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      raw_pixel,
  input  logic                  frame_last,
  output logic                  done,
  output logic [7:0]            display_value,
  output logic [PIX_W-1:0]      offset_value,
  output logic                  frame_end
);

  cfg_t                    cfg;
  stage_t                  mid_ctl;
  logic signed [PIX_W-1:0] mid_value;

  assign busy = 1'b0;

  mpwl_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  mpwl_rescale u_rescale (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (start & ~busy),
    .raw_pixel  (raw_pixel),
    .frame_last (frame_last),
    .out_ctl    (mid_ctl),
    .out_value  (mid_value)
  );

  mpwl_window u_window (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_ctl        (mid_ctl),
    .in_value      (mid_value),
    .done          (done),
    .display_value (display_value),
    .offset_value  (offset_value),
    .frame_end     (frame_end)
  );

endmodule
